// ===== rtl/core/ffha_pkg.sv =====
// ----------------------------------------------------------------------------
// First-fit heap allocator package
// Shared beat types, block kinds, request modes and sequencer states.
// ----------------------------------------------------------------------------
package ffha_pkg;

  // Widths of the fixed request and response fields.
  localparam int unsigned OFF_W  = 12;
  localparam int unsigned NEED_W = OFF_W + 1;

  // Request modes.
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // Kind of a block table entry.
  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_FREE = 2'd1,
    KIND_USED = 2'd2
  } kind_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_A_RD,
    ST_A_EV,
    ST_A_MARK,
    ST_R_RD,
    ST_R_EV,
    ST_N_RD,
    ST_N_EV,
    ST_N_CLR,
    ST_P_RD,
    ST_P_EV,
    ST_P_CLR
  } state_e;

  // Request beat.
  typedef struct packed {
    logic             mode;
    logic [OFF_W-1:0] request_bytes;
    logic [OFF_W-1:0] release_offset;
  } req_t;

  // Response beat.
  typedef struct packed {
    logic [OFF_W-1:0] data_offset;
    logic             failed;
  } rsp_t;

endpackage

// ===== rtl/core/first_fit_heap_allocator.sv =====
// ----------------------------------------------------------------------------
// First-fit heap allocator
// Manages a heap as address-ordered blocks with headers, first-fit allocate
// with splitting, and free with coalescing of both neighbors.
// ----------------------------------------------------------------------------
// A request beat is taken when start is high and busy is low; its single
// response beat is shown on rsp_o for one cycle with done_o high, and it must
// be taken then, since the receiver cannot stall it. All table walks go through
// one block table RAM with a registered read, so each visited block header
// passes through a read state and then an evaluate state. An allocate reads
// each header in turn until the first fitting free block, then marks it; when
// nothing fits, it walks every header in the heap and then sees the end. A
// free checks the block and merges the following neighbor, then visits the
// block headers that lie below it in turn until the preceding neighbor is
// found, and folds into a free preceding block. A free offset below one
// header or past the heap is answered without a table access, in the cycle
// after it is taken, and busy stays low. After reset the block runs a clearing
// pass over all HEAP_BYTES table entries, with busy high, before it takes the
// first request.
module first_fit_heap_allocator
  import ffha_pkg::*;
#(
  parameter int unsigned HEAP_BYTES   = 2048,
  parameter int unsigned HEADER_BYTES = 12
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic done_o,
  output rsp_t rsp_o
);

  localparam int unsigned AW       = $clog2(HEAP_BYTES);
  localparam int unsigned PW       = AW + 1;
  localparam int unsigned CW       = ((AW > NEED_W) ? AW : NEED_W) + 1;
  localparam int unsigned AREA_END = HEAP_BYTES - HEADER_BYTES;
  localparam int unsigned EW       = AW + 2;

  state_e state_q, state_d;

  logic [AW-1:0]     clr_q, clr_d;
  logic [PW-1:0]     pos_q, pos_d;
  logic [NEED_W-1:0] need_q, need_d;
  logic [AW-1:0]     start_q, start_d;
  logic [AW-1:0]     nxt_q, nxt_d;
  logic [AW-1:0]     slen_q, slen_d;
  logic [AW-1:0]     len_q, len_d;
  logic              done_q;
  rsp_t              rsp_q;

  // Table port.
  logic          we;
  logic [AW-1:0] waddr;
  logic [EW-1:0] wdata;
  logic [AW-1:0] raddr;
  logic [EW-1:0] rdata;

  // Response strobe from the sequencer.
  logic             fin;
  logic             fin_fail;
  logic [OFF_W-1:0] fin_off;

  // Decoded table entry and shared compares.
  logic [AW-1:0] rd_len;
  kind_e         rd_kind;
  logic          a_fit, a_bad, a_split, pos_end;
  logic          r_low, r_out, nxt_in, st_zero, p_go, p_hit;
  logic [CW-1:0] r_start;
  logic [PW-1:0] nxt_sum, p_sum, merge_n, merge_p;
  logic [CW-1:0] a_off;

  ffha_ram #(
    .Width(EW),
    .Depth(HEAP_BYTES)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Decode the registered table entry and form the shared compares.
  assign rd_len  = rdata[AW-1:0];
  assign rd_kind = kind_e'(rdata[EW-1:AW]);
  assign a_fit   = (rd_kind == KIND_FREE) && (CW'(rd_len) >= CW'(need_q));
  assign a_bad   = (rd_len == '0) || (rd_kind == KIND_NONE);
  assign a_split = (CW'(rd_len) - CW'(need_q)) > CW'(HEADER_BYTES);
  assign pos_end = pos_q >= PW'(AREA_END);
  assign r_low   = CW'(req_i.release_offset) < CW'(HEADER_BYTES);
  assign r_start = CW'(req_i.release_offset) - CW'(HEADER_BYTES);
  assign r_out   = r_start >= CW'(AREA_END);
  assign nxt_sum = PW'(start_q) + PW'(rd_len);
  assign nxt_in  = nxt_sum < PW'(AREA_END);
  assign st_zero = start_q == '0;
  assign p_sum   = pos_q + PW'(rd_len);
  assign p_go    = pos_q < PW'(start_q);
  assign p_hit   = p_sum == PW'(start_q);
  assign merge_n = PW'(slen_q) + PW'(rd_len);
  assign merge_p = PW'(rd_len) + PW'(slen_q);
  assign a_off   = CW'(pos_q) + CW'(HEADER_BYTES);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == AW'(HEAP_BYTES - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          if (req_i.mode == MODE_ALLOC) state_d = ST_A_RD;
          else if (!(r_low || r_out)) state_d = ST_R_RD;
        end
      end
      ST_A_RD: begin
        state_d = pos_end ? ST_IDLE : ST_A_EV;
      end
      ST_A_EV: begin
        if (a_bad) state_d = ST_IDLE;
        else if (a_fit) state_d = ST_A_MARK;
        else state_d = ST_A_RD;
      end
      ST_A_MARK: state_d = ST_IDLE;
      ST_R_RD:   state_d = ST_R_EV;
      ST_R_EV: begin
        if (rd_kind != KIND_USED) state_d = ST_IDLE;
        else if (nxt_in) state_d = ST_N_RD;
        else state_d = st_zero ? ST_IDLE : ST_P_RD;
      end
      ST_N_RD: state_d = ST_N_EV;
      ST_N_EV: begin
        if (rd_kind == KIND_FREE) state_d = ST_N_CLR;
        else state_d = st_zero ? ST_IDLE : ST_P_RD;
      end
      ST_N_CLR: state_d = st_zero ? ST_IDLE : ST_P_RD;
      ST_P_RD: begin
        state_d = p_go ? ST_P_EV : ST_IDLE;
      end
      ST_P_EV: begin
        if (rd_len == '0) state_d = ST_IDLE;
        else if (p_hit) state_d = (rd_kind == KIND_FREE) ? ST_P_CLR : ST_IDLE;
        else state_d = ST_P_RD;
      end
      ST_P_CLR: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Table accesses, datapath updates and response for each state.
  always_comb begin
    clr_d    = clr_q;
    pos_d    = pos_q;
    need_d   = need_q;
    start_d  = start_q;
    nxt_d    = nxt_q;
    slen_d   = slen_q;
    len_d    = len_q;
    we       = 1'b0;
    waddr    = pos_q[AW-1:0];
    wdata    = {KIND_NONE, AW'(0)};
    raddr    = pos_q[AW-1:0];
    fin      = 1'b0;
    fin_fail = 1'b0;
    fin_off  = '0;
    case (state_q)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = (clr_q == '0) ? {KIND_FREE, AW'(AREA_END)} : {KIND_NONE, AW'(0)};
        clr_d = clr_q + AW'(1);
      end
      ST_IDLE: begin
        if (start) begin
          need_d  = NEED_W'(req_i.request_bytes) + NEED_W'(HEADER_BYTES);
          pos_d   = '0;
          start_d = r_start[AW-1:0];
          if (req_i.mode == MODE_FREE && (r_low || r_out)) begin
            fin      = 1'b1;
            fin_fail = 1'b1;
          end
        end
      end
      ST_A_RD: begin
        if (pos_end) begin
          fin      = 1'b1;
          fin_fail = 1'b1;
        end
      end
      ST_A_EV: begin
        if (a_bad) begin
          fin      = 1'b1;
          fin_fail = 1'b1;
        end else if (a_fit) begin
          len_d = a_split ? AW'(need_q) : rd_len;
          // The remainder becomes a free block right after the taken one.
          if (a_split) begin
            we    = 1'b1;
            waddr = AW'(CW'(pos_q) + CW'(need_q));
            wdata = {KIND_FREE, AW'(CW'(rd_len) - CW'(need_q))};
          end
        end else begin
          pos_d = p_sum;
        end
      end
      ST_A_MARK: begin
        we      = 1'b1;
        wdata   = {KIND_USED, len_q};
        fin     = 1'b1;
        fin_off = a_off[OFF_W-1:0];
      end
      ST_R_RD: begin
        raddr = start_q;
      end
      ST_R_EV: begin
        if (rd_kind != KIND_USED) begin
          fin      = 1'b1;
          fin_fail = 1'b1;
        end else begin
          slen_d = rd_len;
          nxt_d  = nxt_sum[AW-1:0];
          we     = 1'b1;
          waddr  = start_q;
          wdata  = {KIND_FREE, rd_len};
          if (!nxt_in && st_zero) fin = 1'b1;
        end
      end
      ST_N_RD: begin
        raddr = nxt_q;
      end
      ST_N_EV: begin
        // Absorb a free block that follows.
        if (rd_kind == KIND_FREE) begin
          slen_d = AW'(merge_n);
          we     = 1'b1;
          waddr  = start_q;
          wdata  = {KIND_FREE, AW'(merge_n)};
        end else if (st_zero) begin
          fin = 1'b1;
        end
      end
      ST_N_CLR: begin
        we    = 1'b1;
        waddr = nxt_q;
        if (st_zero) fin = 1'b1;
      end
      ST_P_RD: begin
        if (!p_go) fin = 1'b1;
      end
      ST_P_EV: begin
        if (rd_len == '0) begin
          fin = 1'b1;
        end else if (p_hit) begin
          // Fold into a free block that precedes.
          if (rd_kind == KIND_FREE) begin
            we    = 1'b1;
            wdata = {KIND_FREE, AW'(merge_p)};
          end else begin
            fin = 1'b1;
          end
        end else begin
          pos_d = p_sum;
        end
      end
      ST_P_CLR: begin
        we    = 1'b1;
        waddr = start_q;
        fin   = 1'b1;
      end
      default: begin
        fin = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      done_q  <= fin;
    end
  end

  // Datapath and response registers.
  always_ff @(posedge clk_i) begin
    pos_q             <= pos_d;
    need_q            <= need_d;
    start_q           <= start_d;
    nxt_q             <= nxt_d;
    slen_q            <= slen_d;
    len_q             <= len_d;
    rsp_q.data_offset <= fin_off;
    rsp_q.failed      <= fin_fail;
  end

  assign busy   = state_q != ST_IDLE;
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// ===== rtl/core/ffha_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ffha_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/ffha_checker.sv =====
// ----------------------------------------------------------------------------
// First-fit heap allocator port checker
// Watches the top level's ports and flags responses that break its rules.
// ----------------------------------------------------------------------------
module ffha_checker
  import ffha_pkg::*;
#(
  parameter int unsigned HEADER_BYTES = 12
) (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input req_t req_i,
  input logic done_o,
  input rsp_t rsp_o
);

  // An accepted beat either occupies the block or is answered at once.
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy || done_o)
    else $error("accepted request neither started nor answered");

  // A free below the first header is refused at once.
  a_low_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && req_i.mode == MODE_FREE &&
    (13'(req_i.release_offset) < 13'(HEADER_BYTES))
    |=> done_o && rsp_o.failed && rsp_o.data_offset == '0)
    else $error("invalid free not refused");

  // A failed response carries no offset.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.failed |-> rsp_o.data_offset == '0)
    else $error("failed response with nonzero offset");

  // A response beat is only shown once the block is free again.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("response shown while busy");

endmodule

bind first_fit_heap_allocator ffha_checker #(
  .HEADER_BYTES(HEADER_BYTES)
) u_ffha_checker (
  .clk_i (clk_i),
  .rst_ni(rst_ni),
  .start (start),
  .busy  (busy),
  .req_i (req_i),
  .done_o(done_o),
  .rsp_o (rsp_o)
);

// ===== tb/tb_first_fit_heap_allocator.sv =====
// ----------------------------------------------------------------------------
// First-fit heap allocator testbench
// Drives allocate and free requests through the start/busy handshake and
// checks each response beat against a behavioral first-fit heap kept in a
// scoreboard. A directed opening covers exact fits, split limits, bad frees
// and coalescing. The random part mixes well-formed alloc/free traffic with
// bad offsets and oversized requests.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_first_fit_heap_allocator;
  import ffha_pkg::*;

  localparam int unsigned HEAP_BYTES   = 2048;
  localparam int unsigned HEADER_BYTES = 12;
  localparam int unsigned AREA_END     = HEAP_BYTES - HEADER_BYTES;
  localparam int unsigned RANDOM_ITEMS = 925;
  localparam int unsigned IDLE_LIMIT   = 20000;
  localparam int unsigned DRAIN_CYCLES = 500;

  // Behavioral heap and queue of expected response beats.
  class heap_scoreboard;
    int unsigned span_len[HEAP_BYTES];
    kind_e       span_kind[HEAP_BYTES];
    rsp_t        expected_q[$];
    int unsigned live_q[$];
    int unsigned last_freed;
    int unsigned errors;
    int unsigned n_alloc_ok, n_alloc_fail, n_free_ok, n_free_bad, n_checked;

    function new();
      for (int i = 0; i < HEAP_BYTES; i++) begin
        span_len[i]  = 0;
        span_kind[i] = KIND_NONE;
      end
      span_len[0]  = AREA_END;
      span_kind[0] = KIND_FREE;
      last_freed   = HEADER_BYTES;
    endfunction

    task report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    // Apply one accepted request to the heap and queue its expected beat.
    function void note_request(input req_t r);
      rsp_t        exp_rsp;
      int unsigned need, pos, len, blk, nxt, off;
      exp_rsp = '0;
      if (r.mode == MODE_ALLOC) begin
        // First-fit walk over the tiling, splitting only above one header.
        need = int'(r.request_bytes) + HEADER_BYTES;
        exp_rsp.failed = 1'b1;
        pos = 0;
        while (pos < AREA_END) begin
          len = span_len[pos];
          if (len == 0 || span_kind[pos] == KIND_NONE) break;
          if (span_kind[pos] == KIND_FREE && len >= need) begin
            if (len - need > HEADER_BYTES) begin
              span_len[pos + need]  = len - need;
              span_kind[pos + need] = KIND_FREE;
              span_len[pos]         = need;
            end
            span_kind[pos]      = KIND_USED;
            exp_rsp.data_offset = OFF_W'(pos + HEADER_BYTES);
            exp_rsp.failed      = 1'b0;
            live_q.push_back(pos + HEADER_BYTES);
            break;
          end
          pos += len;
        end
        if (exp_rsp.failed) n_alloc_fail++;
        else n_alloc_ok++;
      end else begin
        off = 32'(r.release_offset);
        blk = off - HEADER_BYTES;
        if (off < HEADER_BYTES || blk >= AREA_END || span_kind[blk] != KIND_USED) begin
          exp_rsp.failed = 1'b1;
          n_free_bad++;
        end else begin
          span_kind[blk] = KIND_FREE;
          // Merge with the following block when it is free.
          nxt = blk + span_len[blk];
          if (nxt < AREA_END && span_kind[nxt] == KIND_FREE) begin
            span_len[blk] += span_len[nxt];
            span_len[nxt]  = 0;
            span_kind[nxt] = KIND_NONE;
          end
          // Find the preceding block and merge into it when it is free.
          pos = 0;
          while (pos < blk) begin
            len = span_len[pos];
            if (len == 0) break;
            if (pos + len == blk) begin
              if (span_kind[pos] == KIND_FREE) begin
                span_len[pos] += span_len[blk];
                span_len[blk]  = 0;
                span_kind[blk] = KIND_NONE;
              end
              break;
            end
            pos += len;
          end
          foreach (live_q[i]) begin
            if (live_q[i] == off) begin
              live_q.delete(i);
              break;
            end
          end
          last_freed = off;
          n_free_ok++;
        end
      end
      expected_q.push_back(exp_rsp);
    endfunction

    // Compare one response beat with the oldest expectation.
    task check_response(input rsp_t got);
      rsp_t exp_rsp;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("response offset=%0d failed=%0b with nothing pending",
                                  got.data_offset, got.failed));
      end else begin
        exp_rsp = expected_q.pop_front();
        n_checked++;
        if (got.data_offset !== exp_rsp.data_offset)
          report_mismatch($sformatf("data_offset got %0d expected %0d",
                                    got.data_offset, exp_rsp.data_offset));
        if (got.failed !== exp_rsp.failed)
          report_mismatch($sformatf("failed got %0b expected %0b",
                                    got.failed, exp_rsp.failed));
      end
    endtask
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  logic busy;
  req_t req    = '0;
  logic done_o;
  rsp_t rsp;

  heap_scoreboard sb = new();
  int unsigned    burst_left = 0;
  int unsigned    idle_cycles = 0;

  first_fit_heap_allocator #(
    .HEAP_BYTES  (HEAP_BYTES),
    .HEADER_BYTES(HEADER_BYTES)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .req_i (req),
    .done_o(done_o),
    .rsp_o (rsp)
  );

  always #5 clk_i = ~clk_i;

  // Response monitor: every done beat is checked on the edge that ends it.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_response(rsp);
  end

  // Watchdog on cycles without any accepted beat in either direction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no beat for %0d cycles", IDLE_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // Send one request beat, with sender gaps between bursts. The field that the
  // mode does not use carries random content.
  task send_request(input logic mode, input int unsigned nbytes, input int unsigned off);
    req_t r;
    int unsigned gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        gap = $urandom_range(1, 40);
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 25);
    end
    burst_left--;
    r.mode           = mode;
    r.request_bytes  = (mode == MODE_ALLOC) ? OFF_W'(nbytes) : OFF_W'($urandom);
    r.release_offset = (mode == MODE_FREE) ? OFF_W'(off) : OFF_W'($urandom);
    start <= 1'b1;
    req   <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_request(r);
  endtask

  initial begin
    int unsigned sel, idx, n, cnt;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed opening: limits of the fields, exact fits and split threshold.
    send_request(MODE_ALLOC, 0, 0);
    send_request(MODE_FREE, 0, 12);
    send_request(MODE_FREE, 0, 12);       // double free
    send_request(MODE_FREE, 0, 0);        // offset below one header
    send_request(MODE_FREE, 0, 11);
    send_request(MODE_FREE, 0, 4095);     // beyond the heap
    send_request(MODE_FREE, 0, 2048);
    send_request(MODE_ALLOC, 4095, 0);    // can never fit
    send_request(MODE_ALLOC, 2025, 0);    // one byte too many
    send_request(MODE_ALLOC, 2024, 0);    // exact fit of the whole heap
    send_request(MODE_FREE, 0, 12);
    send_request(MODE_ALLOC, 2012, 0);    // remainder of exactly one header
    send_request(MODE_FREE, 0, 12);
    send_request(MODE_ALLOC, 2011, 0);    // remainder just above one header
    send_request(MODE_ALLOC, 0, 0);       // takes the small remainder whole
    send_request(MODE_FREE, 0, 12);
    send_request(MODE_FREE, 0, 2035);     // merges into the free block below
    // Coalescing with each neighbor and with both.
    send_request(MODE_ALLOC, 100, 0);
    send_request(MODE_ALLOC, 100, 0);
    send_request(MODE_ALLOC, 100, 0);
    send_request(MODE_FREE, 0, 13);       // inside an allocated block
    send_request(MODE_FREE, 0, 12);
    send_request(MODE_FREE, 0, 236);
    send_request(MODE_FREE, 0, 124);
    send_request(MODE_ALLOC, 2024, 0);
    send_request(MODE_FREE, 0, 12);

    // Random traffic: mostly legal alloc/free with noise mixed in.
    cnt = 0;
    while (cnt < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 99);
      if (sel < 2 && sb.live_q.size() > 0) begin
        // Release everything in random order to exercise deep merging.
        while (sb.live_q.size() > 0 && cnt < RANDOM_ITEMS) begin
          idx = $urandom_range(0, sb.live_q.size() - 1);
          send_request(MODE_FREE, 0, sb.live_q[idx]);
          cnt++;
        end
      end else if (sel < ((sb.live_q.size() < 40) ? 55 : 35) || sb.live_q.size() == 0) begin
        n = $urandom_range(0, 99);
        if (n < 70) n = $urandom_range(0, 64);
        else if (n < 95) n = $urandom_range(0, 600);
        else n = $urandom_range(0, 4095);
        send_request(MODE_ALLOC, n, 0);
        cnt++;
      end else if (sel < 88) begin
        idx = $urandom_range(0, sb.live_q.size() - 1);
        send_request(MODE_FREE, 0, sb.live_q[idx]);
        cnt++;
      end else if (sel < 92) begin
        idx = $urandom_range(0, sb.live_q.size() - 1);
        send_request(MODE_FREE, 0, sb.live_q[idx] + $urandom_range(1, 11));
        cnt++;
      end else if (sel < 95) begin
        send_request(MODE_FREE, 0, sb.last_freed);
        cnt++;
      end else begin
        send_request(MODE_FREE, 0, $urandom_range(0, 4095));
        cnt++;
      end
    end
    start <= 1'b0;

    // Let outstanding responses arrive, then watch for stray beats.
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.expected_q.size() != 0)
      sb.report_mismatch($sformatf("%0d responses never arrived", sb.expected_q.size()));

    $display("Checked %0d responses: %0d allocations granted, %0d refused,",
             sb.n_checked, sb.n_alloc_ok, sb.n_alloc_fail);
    $display("  %0d frees accepted, %0d bad frees rejected, %0d mismatches.",
             sb.n_free_ok, sb.n_free_bad, sb.errors);
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== first_fit_heap_allocator.f =====
rtl/core/ffha_pkg.sv
rtl/core/ffha_ram.sv
rtl/core/first_fit_heap_allocator.sv
rtl/core/ffha_checker.sv
tb/tb_first_fit_heap_allocator.sv
